### rtl/cars_pkg.sv
package cars_pkg;

    localparam int COORD_W        = 16;
    localparam int EDGE_W         = 17;
    localparam int GRID_W         = 8;
    localparam int SPAN_W         = 17;
    localparam int PROD_W         = 24;
    localparam int QUOT_W         = 17;
    localparam int LANES          = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_COUNT_BITS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_FIRST      = 3'd0,
        REG_Y_FIRST      = 3'd1,
        REG_X_SECOND     = 3'd2,
        REG_Y_SECOND     = 3'd3,
        REG_COLUMN_COUNT = 3'd4,
        REG_ROW_COUNT    = 3'd5
    } cfg_reg_t;

    localparam int LANE_X_START = 0;
    localparam int LANE_X_END   = 1;
    localparam int LANE_Y_START = 2;
    localparam int LANE_Y_END   = 3;

endpackage

### rtl/cell_array_rect_splitter.sv
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_stall   | pen_index
// out      | out_valid / out_stall | cell_left cell_top cell_right cell_bottom
//          |                       | pen_out last_cell
// cfg      | cfg_valid / cfg_ready | cfg_index cfg_data
//
// an item with a nonzero grid forms the four dividends as it is accepted, then takes 24 steps
// of the bit-serial restoring dividers (one quotient bit per cycle), then adds the corner
// a zero column or row count consumes the item and emits nothing
// rst_n clears the counters, the state and out_valid; corners reset to 0, counts to 1
// a finished result waits in the output register while out_stall is high; the next item
// is accepted meanwhile, its result is held in the dividers until the output frees up
module cell_array_rect_splitter
    import cars_pkg::*;
#(
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [COORD_W-1:0]          cfg_data,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [COORD_W-1:0]   pen_index,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [COORD_W-1:0]   cell_left,
    output logic signed [COORD_W-1:0]   cell_top,
    output logic signed [EDGE_W-1:0]    cell_right,
    output logic signed [EDGE_W-1:0]    cell_bottom,
    output logic signed [COORD_W-1:0]   pen_out,
    output logic                        last_cell
);

    localparam int CMP_W  = (COUNT_BITS > GRID_W) ? COUNT_BITS : GRID_W;
    localparam int STEP_W = $clog2(PROD_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(PROD_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    logic signed [COORD_W-1:0] x_first_reg, y_first_reg, x_second_reg, y_second_reg;
    logic [GRID_W-1:0]         column_count_reg, row_count_reg;

    logic [COUNT_BITS-1:0] col_pos_reg, row_pos_reg;
    logic [COUNT_BITS-1:0] col_eff, row_eff;
    logic [COUNT_BITS-1:0] col_pos_next, row_pos_next;
    logic                  col_end, row_end, grid_last;
    logic                  zero_grid, in_xfer, out_free, load_out;

    logic signed [COORD_W-1:0] x_min, x_max, y_min, y_max;
    logic [SPAN_W-1:0]         span_x, span_y;
    logic [GRID_W-1:0]         col_idx, row_idx;
    logic [PROD_W-1:0]         lane_load [LANES];
    logic [GRID_W-1:0]         lane_divisor [LANES];

    logic [PROD_W-1:0] quo_reg [LANES];
    logic [GRID_W-1:0] rem_reg [LANES];
    logic [STEP_W-1:0] step_reg;
    logic signed [COORD_W-1:0] pen_reg;
    logic              last_reg;

    logic [COORD_W+1:0] left_sum, right_sum, top_sum, bottom_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_first_reg      <= '0;
            y_first_reg      <= '0;
            x_second_reg     <= '0;
            y_second_reg     <= '0;
            column_count_reg <= GRID_W'(1);
            row_count_reg    <= GRID_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_X_FIRST:      x_first_reg      <= cfg_data;
                REG_Y_FIRST:      y_first_reg      <= cfg_data;
                REG_X_SECOND:     x_second_reg     <= cfg_data;
                REG_Y_SECOND:     y_second_reg     <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data[GRID_W-1:0];
                REG_ROW_COUNT:    row_count_reg    <= cfg_data[GRID_W-1:0];
                default:          ;
            endcase
        end
    end

    // corners in order
    always_comb
    begin
        x_min  = (x_first_reg > x_second_reg) ? x_second_reg : x_first_reg;
        x_max  = (x_first_reg > x_second_reg) ? x_first_reg : x_second_reg;
        y_min  = (y_first_reg > y_second_reg) ? y_second_reg : y_first_reg;
        y_max  = (y_first_reg > y_second_reg) ? y_first_reg : y_second_reg;
        span_x = SPAN_W'({x_max[COORD_W-1], x_max} - {x_min[COORD_W-1], x_min}) + SPAN_W'(1);
        span_y = SPAN_W'({y_max[COORD_W-1], y_max} - {y_min[COORD_W-1], y_min}) + SPAN_W'(1);
    end

    // grid position and counter advance
    always_comb
    begin
        zero_grid = (column_count_reg == '0) || (row_count_reg == '0);
        col_eff   = (CMP_W'(col_pos_reg) >= CMP_W'(column_count_reg)) ? '0 : col_pos_reg;
        row_eff   = (CMP_W'(row_pos_reg) >= CMP_W'(row_count_reg)) ? '0 : row_pos_reg;
        col_end   = ((CMP_W + 1)'(col_eff) + 1'b1) == (CMP_W + 1)'(column_count_reg);
        row_end   = ((CMP_W + 1)'(row_eff) + 1'b1) == (CMP_W + 1)'(row_count_reg);
        grid_last = col_end && row_end;
        col_idx   = GRID_W'(col_eff);
        row_idx   = GRID_W'(row_eff);
        if (grid_last)
        begin
            col_pos_next = '0;
            row_pos_next = '0;
        end
        else if (col_end)
        begin
            col_pos_next = '0;
            row_pos_next = row_eff + 1'b1;
        end
        else
        begin
            col_pos_next = col_eff + 1'b1;
            row_pos_next = row_eff;
        end
    end

    always_comb
    begin
        lane_load[LANE_X_START] = PROD_W'(25'(col_idx) * 25'(span_x));
        lane_load[LANE_X_END]   = PROD_W'((25'(col_idx) + 25'd1) * 25'(span_x));
        lane_load[LANE_Y_START] = PROD_W'(25'(row_idx) * 25'(span_y));
        lane_load[LANE_Y_END]   = PROD_W'((25'(row_idx) + 25'd1) * 25'(span_y));
        lane_divisor[LANE_X_START] = column_count_reg;
        lane_divisor[LANE_X_END]   = column_count_reg;
        lane_divisor[LANE_Y_START] = row_count_reg;
        lane_divisor[LANE_Y_END]   = row_count_reg;
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid || !out_stall;
    assign load_out = (state_reg == ST_DONE) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_xfer && !zero_grid)
                    state_next = ST_DIV;
            ST_DIV:
                if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // restoring dividers, one quotient bit per lane per cycle
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [GRID_W:0] rem_shift;
        logic            fits;

        always_comb
        begin
            rem_shift = {rem_reg[g], quo_reg[g][PROD_W-1]};
            fits      = rem_shift >= {1'b0, lane_divisor[g]};
        end

        always_ff @(posedge clk)
        begin
            if (in_xfer)
            begin
                quo_reg[g] <= lane_load[g];
                rem_reg[g] <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                quo_reg[g] <= {quo_reg[g][PROD_W-2:0], fits};
                rem_reg[g] <= fits ? GRID_W'(rem_shift - {1'b0, lane_divisor[g]})
                                   : GRID_W'(rem_shift);
            end
        end
    end

    always_comb
    begin
        left_sum   = {{2{x_min[COORD_W-1]}}, x_min}
                   + {1'b0, quo_reg[LANE_X_START][QUOT_W-1:0]};
        right_sum  = {{2{x_min[COORD_W-1]}}, x_min}
                   + {1'b0, quo_reg[LANE_X_END][QUOT_W-1:0]} - 18'd1;
        top_sum    = {{2{y_min[COORD_W-1]}}, y_min}
                   + {1'b0, quo_reg[LANE_Y_START][QUOT_W-1:0]};
        bottom_sum = {{2{y_min[COORD_W-1]}}, y_min}
                   + {1'b0, quo_reg[LANE_Y_END][QUOT_W-1:0]} - 18'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            col_pos_reg <= '0;
            row_pos_reg <= '0;
            step_reg    <= '0;
            out_valid   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer && !zero_grid)
            begin
                col_pos_reg <= col_pos_next;
                row_pos_reg <= row_pos_next;
                pen_reg     <= pen_index;
                last_reg    <= grid_last;
                step_reg    <= '0;
            end
            else if (state_reg == ST_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid   <= 1'b1;
                cell_left   <= left_sum[COORD_W-1:0];
                cell_top    <= top_sum[COORD_W-1:0];
                cell_right  <= right_sum[EDGE_W-1:0];
                cell_bottom <= bottom_sum[EDGE_W-1:0];
                pen_out     <= pen_reg;
                last_cell   <= last_reg;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_zero_grid_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && zero_grid |=> state_reg == ST_IDLE)
        else $error("zero grid started a cell");

    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && step_reg == STEP_LAST |=> state_reg == ST_DONE)
        else $error("divider did not finish on its last step");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !zero_grid |=> CMP_W'(col_pos_reg) < CMP_W'(column_count_reg))
        else $error("column position left the grid");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !zero_grid |=> CMP_W'(row_pos_reg) < CMP_W'(row_count_reg))
        else $error("row position left the grid");
`endif

endmodule
